/* sv/tli_pkg.sv */
package tli_pkg;

   localparam int DATA_W = 32;

   // Request kinds.
   localparam logic [1:0] KIND_TIME     = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_FALLBACK = 2'd2;
   localparam logic [1:0] KIND_QUERY    = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_DIV,
      S_V_RD,
      S_V_DIFF,
      S_V_MUL,
      S_V_SUM
   } state_type;

   typedef struct packed {
      logic        start;
      logic [32:0] num;
      logic [32:0] den;
   } div_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
   } div_sts_type;

endpackage

/* sv/tli_if.sv */
interface tli_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  point_index;
   logic [5:0]  channel_index;
   logic signed [31:0] time_value;
   logic signed [31:0] data_value;
   modport source (output valid, kind, point_index, channel_index, time_value,
                   data_value, input ready);
   modport sink (input valid, kind, point_index, channel_index, time_value,
                 data_value, output ready);
endinterface

interface tli_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  out_channel;
   logic signed [31:0] out_value;
   logic signed [31:0] out_time;
   logic        last_of_run;
   modport source (output valid, out_channel, out_value, out_time, last_of_run,
                   input ready);
   modport sink (input valid, out_channel, out_value, out_time, last_of_run,
                 output ready);
endinterface

interface tli_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* sv/trajectory_linear_interpolator_core.sv */
// Channel   Direction  Carries
// req_ch    in         kind, point_index, channel_index, time_value, data_value
// rsp_ch    out        out_channel, out_value, out_time, last_of_run
// csr_ch    in         point_count (9 bits)
//
// Table writes (kinds 0, 1, 2) give no result.
// A query checks the end points, runs a binary search over the point time
// memory with a read and a compare step per probe plus a closing step,
// runs the serial divider for the weight when the time lies in the final
// bracket, and then takes each channel through the value memory read,
// difference, multiply and rounding stages; an empty table goes straight
// to the channel stages.
// Reset clears the control state, point_count and the fallback valid bits;
// a fallback entry never written reads as zero. A stalled result port holds
// the channel pipeline at its last stage; requests are taken only while idle.
module trajectory_linear_interpolator_core #(
   parameter int MAX_POINTS = 256,
   parameter int CHANNELS = 40
) (
   input  logic      clock,
   input  logic      reset,
   tli_req_if.sink   req_ch,
   tli_rsp_if.source rsp_ch,
   tli_csr_if.sink   csr_ch
);

   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int VDEPTH = MAX_POINTS * CHANNELS;
   localparam int AW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

   tli_pkg::state_type state_ff, state_in;

   logic [8:0]        point_count_ff;
   logic signed [31:0] t_ff, t_in;
   logic [31:0]       t0_ff, t0_in;
   logic [31:0]       t1_ff, t1_in;
   logic [PW-1:0]     left_ff, left_in;
   logic [PW-1:0]     right_ff, right_in;
   logic [PW-1:0]     mid_ff, mid_in;
   logic [PW-1:0]     lastidx_ff, lastidx_in;
   logic              fallback_ff, fallback_in;
   logic [31:0]       alpha_ff, alpha_in;
   logic [CW-1:0]     chan_ff, chan_in;
   logic [31:0]       v0_ff, v0_in;
   logic              neg_ff, neg_in;
   logic [31:0]       mag_ff, mag_in;
   logic [63:0]       prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rsp_chan_ff, rsp_chan_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [31:0]       rsp_time_ff, rsp_time_in;
   logic              rsp_last_ff, rsp_last_in;

   // Fallback vector: a small memory with valid bits so reset reads as zero.
   logic [31:0]       fb_mem [CHANNELS];
   logic [CHANNELS-1:0] fb_vld_ff;
   logic [31:0]       fb_rd_ff;
   logic              fb_rd_vld_ff;

   logic              req_fire;
   logic              is_query;
   logic [NW-1:0]     n_c;
   logic [PW:0]       sum_lr;
   logic              can_split;
   logic signed [32:0] dt_c;
   logic signed [32:0] tdiff_c;
   logic              div_ok;
   logic              out_free;
   logic              last_chan;
   logic [PW-1:0]     t_rd_addr;
   logic [31:0]       t_rd_data;
   logic              t_we;
   logic              v_we;
   logic              fb_we;
   logic [AW-1:0]     v_wr_addr;
   logic [AW-1:0]     v_rd_addr0;
   logic [AW-1:0]     v_rd_addr1;
   logic [31:0]       v_rd_data0;
   logic [31:0]       v_rd_data1;
   logic [31:0]       v0_c;
   logic [31:0]       v1_c;
   logic signed [32:0] vdiff_c;
   logic [63:0]       round_c;
   logic [31:0]       step_c;

   tli_pkg::div_ctl_type div_ctl;
   tli_pkg::div_sts_type div_sts;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign is_query  = req_ch.kind == tli_pkg::KIND_QUERY;
   assign req_ch.ready = state_ff == tli_pkg::S_IDLE;
   assign csr_ch.ready = 1'b1;

   // A count above the table depth is clamped to the depth.
   always_comb begin
      if (32'(point_count_ff) > MAX_POINTS) begin
         n_c = NW'(MAX_POINTS);
      end else begin
         n_c = NW'(point_count_ff);
      end
   end

   assign sum_lr    = (PW + 1)'(left_ff) + (PW + 1)'(right_ff);
   assign can_split = ((PW + 1)'(left_ff) + (PW + 1)'(1)) < (PW + 1)'(right_ff);
   assign dt_c      = {t1_ff[31], t1_ff} - {t0_ff[31], t0_ff};
   assign tdiff_c   = {t_ff[31], t_ff} - {t0_ff[31], t0_ff};
   assign div_ok    = (dt_c > 33'sd0) && (tdiff_c >= 33'sd0) && (tdiff_c < dt_c);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign last_chan = chan_ff == CW'(CHANNELS - 1);

   // Table writes.
   assign t_we  = req_fire && (req_ch.kind == tli_pkg::KIND_TIME)
                  && (32'(req_ch.point_index) < MAX_POINTS);
   assign v_we  = req_fire && (req_ch.kind == tli_pkg::KIND_VALUE)
                  && (32'(req_ch.point_index) < MAX_POINTS)
                  && (32'(req_ch.channel_index) < CHANNELS);
   assign fb_we = req_fire && (req_ch.kind == tli_pkg::KIND_FALLBACK)
                  && (32'(req_ch.channel_index) < CHANNELS);
   assign v_wr_addr = AW'(PW'(req_ch.point_index)) * AW'(CHANNELS)
                      + AW'(req_ch.channel_index);
   assign v_rd_addr0 = AW'(left_ff) * AW'(CHANNELS) + AW'(chan_ff);
   assign v_rd_addr1 = AW'(right_ff) * AW'(CHANNELS) + AW'(chan_ff);

   // Time memory read address follows the search phase.
   always_comb begin
      case (state_ff)
         tli_pkg::S_FIRST:     t_rd_addr = lastidx_ff;
         tli_pkg::S_SEARCH_RD: t_rd_addr = PW'(sum_lr >> 1);
         default:              t_rd_addr = '0;
      endcase
   end

   tli_tmem #(.DEPTH(MAX_POINTS), .AW(PW)) u_tmem (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (PW'(req_ch.point_index)),
      .wr_data (req_ch.time_value),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   tli_vmem #(.DEPTH(VDEPTH), .AW(AW)) u_vmem (
      .clock    (clock),
      .wr_en    (v_we),
      .wr_addr  (v_wr_addr),
      .wr_data  (req_ch.data_value),
      .rd_addr0 (v_rd_addr0),
      .rd_addr1 (v_rd_addr1),
      .rd_data0 (v_rd_data0),
      .rd_data1 (v_rd_data1)
   );

   tli_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_mem[CW'(req_ch.channel_index)] <= req_ch.data_value;
      end
      fb_rd_ff     <= fb_mem[chan_ff];
      fb_rd_vld_ff <= fb_vld_ff[chan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_vld_ff <= '0;
      end else if (fb_we) begin
         fb_vld_ff[CW'(req_ch.channel_index)] <= 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            if (req_fire && is_query) begin
               state_in = (n_c == '0) ? tli_pkg::S_V_RD : tli_pkg::S_FIRST;
            end
         end
         tli_pkg::S_FIRST: begin
            state_in = (t_ff <= $signed(t_rd_data)) ? tli_pkg::S_V_RD : tli_pkg::S_LAST;
         end
         tli_pkg::S_LAST: begin
            state_in = (t_ff >= $signed(t_rd_data)) ? tli_pkg::S_V_RD
                                                     : tli_pkg::S_SEARCH_RD;
         end
         tli_pkg::S_SEARCH_RD: begin
            if (can_split) begin
               state_in = tli_pkg::S_SEARCH_CMP;
            end else if (div_ok) begin
               state_in = tli_pkg::S_DIV;
            end else begin
               state_in = tli_pkg::S_V_RD;
            end
         end
         tli_pkg::S_SEARCH_CMP: state_in = tli_pkg::S_SEARCH_RD;
         tli_pkg::S_DIV: begin
            if (div_sts.done) begin
               state_in = tli_pkg::S_V_RD;
            end
         end
         tli_pkg::S_V_RD:   state_in = tli_pkg::S_V_DIFF;
         tli_pkg::S_V_DIFF: state_in = tli_pkg::S_V_MUL;
         tli_pkg::S_V_MUL:  state_in = tli_pkg::S_V_SUM;
         tli_pkg::S_V_SUM: begin
            if (out_free) begin
               state_in = last_chan ? tli_pkg::S_IDLE : tli_pkg::S_V_RD;
            end
         end
         default: state_in = tli_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      t_in        = t_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      mid_in      = mid_ff;
      lastidx_in  = lastidx_ff;
      fallback_in = fallback_ff;
      alpha_in    = alpha_ff;
      chan_in     = chan_ff;
      v0_in       = v0_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      prod_in     = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_value_in = rsp_value_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;
      div_ctl.start = 1'b0;
      div_ctl.num   = tdiff_c;
      div_ctl.den   = dt_c;

      // Held and fallback values go through the same arithmetic with a zero
      // weight, which leaves v0 unchanged.
      v0_c = fallback_ff ? (fb_rd_vld_ff ? fb_rd_ff : 32'd0) : v_rd_data0;
      v1_c = fallback_ff ? v0_c : v_rd_data1;
      vdiff_c = {v1_c[31], v1_c} - {v0_c[31], v0_c};
      round_c = prod_ff + 64'h0000_0000_8000_0000;
      step_c  = round_c[63:32];

      case (state_ff)
         tli_pkg::S_IDLE: begin
            if (req_fire && is_query) begin
               t_in        = req_ch.time_value;
               lastidx_in  = PW'(n_c - NW'(1));
               fallback_in = n_c == '0;
               alpha_in    = '0;
               chan_in     = '0;
               left_in     = '0;
               right_in    = '0;
            end
         end
         tli_pkg::S_FIRST: begin
            t0_in = t_rd_data;
         end
         tli_pkg::S_LAST: begin
            if (t_ff >= $signed(t_rd_data)) begin
               left_in  = lastidx_ff;
               right_in = lastidx_ff;
            end else begin
               t1_in    = t_rd_data;
               right_in = lastidx_ff;
            end
         end
         tli_pkg::S_SEARCH_RD: begin
            mid_in = PW'(sum_lr >> 1);
            if (!can_split && div_ok) begin
               div_ctl.start = 1'b1;
            end
         end
         tli_pkg::S_SEARCH_CMP: begin
            if ($signed(t_rd_data) <= t_ff) begin
               left_in = mid_ff;
               t0_in   = t_rd_data;
            end else begin
               right_in = mid_ff;
               t1_in    = t_rd_data;
            end
         end
         tli_pkg::S_DIV: begin
            if (div_sts.done) begin
               alpha_in = div_sts.quot;
            end
         end
         tli_pkg::S_V_DIFF: begin
            v0_in  = v0_c;
            neg_in = vdiff_c < 33'sd0;
            mag_in = (vdiff_c < 33'sd0) ? 32'(-vdiff_c) : 32'(vdiff_c);
         end
         tli_pkg::S_V_MUL: begin
            prod_in = 64'(alpha_ff) * 64'(mag_ff);
         end
         tli_pkg::S_V_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = 6'(chan_ff);
               rsp_value_in = neg_ff ? (v0_ff - step_c) : (v0_ff + step_c);
               rsp_time_in  = t_ff;
               rsp_last_in  = last_chan;
               chan_in      = chan_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tli_pkg::S_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            point_count_ff <= csr_ch.data;
         end
      end
      t_ff         <= t_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      mid_ff       <= mid_in;
      lastidx_ff   <= lastidx_in;
      fallback_ff  <= fallback_in;
      alpha_ff     <= alpha_in;
      chan_ff      <= chan_in;
      v0_ff        <= v0_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_value_ff <= rsp_value_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_channel = rsp_chan_ff;
   assign rsp_ch.out_value   = rsp_value_ff;
   assign rsp_ch.out_time    = rsp_time_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   // The last flag only ever rides on the final channel.
   a_last_chan : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_of_run) |-> (rsp_ch.out_channel == 6'(CHANNELS - 1)))
      else $error("last flag on a channel other than the final one");

   // The divider only finishes while the controller waits for it.
   a_div_done : assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == tli_pkg::S_DIV))
      else $error("divider result arrived outside the division phase");

   // The search bracket never collapses while the search is running.
   a_bracket : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tli_pkg::S_SEARCH_CMP) |-> (left_ff < mid_ff && mid_ff < right_ff))
      else $error("search bracket out of order");

endmodule

/* sv/tli_tmem.sv */
module tli_tmem #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tli_vmem.sv */
module tli_vmem #(
   parameter int DEPTH = 10240,
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [31:0]   rd_data0,
   output logic [31:0]   rd_data1
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd0_ff;
   logic [31:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

/* sv/tli_div.sv */
// Restoring divider, one quotient bit per cycle. The numerator must be
// below the denominator, so the quotient is a 32-bit fraction.
module tli_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tli_pkg::div_ctl_type ctl,
   output tli_pkg::div_sts_type sts
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [31:0] quot_ff, quot_in;
   logic [33:0] rem_sh;
   logic [33:0] rem_sub;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = ctl.num;
         den_in  = ctl.den;
         quot_in = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[30:0], ge};
         rem_in  = ge ? rem_sub[32:0] : rem_sh[32:0];
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = quot_ff;

endmodule
